// ----- hw/rtl/asgr_pkg.sv -----
package asgr_pkg;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_TEXT = 3'b001,
    PH_ESC  = 3'b010,
    PH_CSI  = 3'b100
  } phase_t;

  // Display attributes, bit 0 bold up to bits 9..7 background
  typedef struct packed {
    logic [2:0] bg;
    logic [2:0] fg;
    logic       reverse;
    logic       blink;
    logic       underline;
    logic       bold;
  } attr_t;

  // Complete parser state carried between the step logic and the top level
  typedef struct packed {
    phase_t     phase;
    logic [6:0] value;
    logic       has_digit;
    logic       bad;
    attr_t      work;
    attr_t      commit;
  } pstate_t;

  // Result kinds
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_ATTR = 1'b1;

  // Configuration register indexes
  localparam logic CFG_IDX_FG = 1'b0;
  localparam logic CFG_IDX_BG = 1'b1;

  // Register reset values
  localparam logic [2:0] FG_RESET = 3'd7;
  localparam logic [2:0] BG_RESET = 3'd0;

  // Byte codes
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_FIN_LO = 8'd64;
  localparam logic [7:0] CH_SCS_HI = 8'd95;
  localparam logic [7:0] CH_FIN_HI = 8'd126;

  // Parameter value limit
  localparam logic [10:0] VALUE_LIMIT = 11'd100;

  // SGR codes
  localparam logic [6:0] SGR_RESET     = 7'd0;
  localparam logic [6:0] SGR_BOLD      = 7'd1;
  localparam logic [6:0] SGR_UNDERLINE = 7'd4;
  localparam logic [6:0] SGR_BLINK     = 7'd5;
  localparam logic [6:0] SGR_REVERSE   = 7'd7;
  localparam logic [6:0] SGR_FG_LO     = 7'd30;
  localparam logic [6:0] SGR_FG_HI     = 7'd37;
  localparam logic [6:0] SGR_FG_DEF    = 7'd39;
  localparam logic [6:0] SGR_BG_LO     = 7'd40;
  localparam logic [6:0] SGR_BG_HI     = 7'd47;
  localparam logic [6:0] SGR_BG_DEF    = 7'd49;

endpackage

// ----- hw/rtl/asgr_step.sv -----
module asgr_step (
  input  asgr_pkg::pstate_t cur,
  input  logic [7:0]        byte_in,
  input  logic [2:0]        rst_fg,
  input  logic [2:0]        rst_bg,
  output asgr_pkg::pstate_t nxt,
  output logic              emit,
  output logic              kind
);
  import asgr_pkg::*;

  logic [10:0] acc;
  logic [3:0]  digit;
  logic        is_digit;
  logic        is_final;
  attr_t       applied;
  attr_t       dflt;

  assign digit    = 4'(byte_in - CH_ZERO);
  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign is_final = (byte_in >= CH_FIN_LO) && (byte_in <= CH_FIN_HI);

  // Accumulate the next decimal digit
  assign acc = ({4'd0, cur.value} << 3) + ({4'd0, cur.value} << 1) + {7'd0, digit};

  // Apply the current parameter to the working copy
  always_comb begin
    dflt    = '0;
    dflt.fg = rst_fg;
    dflt.bg = rst_bg;
    applied = cur.work;
    if (cur.has_digit && !cur.bad) begin
      if (cur.value == SGR_RESET) begin
        applied = dflt;
      end else if (cur.value == SGR_BOLD) begin
        applied.bold = 1'b1;
      end else if (cur.value == SGR_UNDERLINE) begin
        applied.underline = 1'b1;
      end else if (cur.value == SGR_BLINK) begin
        applied.blink = 1'b1;
      end else if (cur.value == SGR_REVERSE) begin
        applied.reverse = 1'b1;
      end else if (cur.value >= SGR_FG_LO && cur.value <= SGR_FG_HI) begin
        applied.fg = 3'(cur.value - SGR_FG_LO);
      end else if (cur.value == SGR_FG_DEF) begin
        applied.fg = rst_fg;
      end else if (cur.value >= SGR_BG_LO && cur.value <= SGR_BG_HI) begin
        applied.bg = 3'(cur.value - SGR_BG_LO);
      end else if (cur.value == SGR_BG_DEF) begin
        applied.bg = rst_bg;
      end
    end
  end

  // Advance the parser by one byte
  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    kind = KIND_TEXT;
    unique case (cur.phase)
      PH_ESC: begin
        if (byte_in == CH_LBRACK) begin
          nxt.phase     = PH_CSI;
          nxt.value     = '0;
          nxt.has_digit = 1'b0;
          nxt.bad       = 1'b0;
          nxt.work      = cur.commit;
        end else begin
          nxt.phase = PH_TEXT;
          emit      = !((byte_in >= CH_FIN_LO) && (byte_in <= CH_SCS_HI));
        end
      end
      PH_CSI: begin
        if (is_digit) begin
          nxt.value     = (acc > VALUE_LIMIT) ? VALUE_LIMIT[6:0] : acc[6:0];
          nxt.has_digit = 1'b1;
        end else if (byte_in == CH_SEMI || is_final) begin
          nxt.work      = applied;
          nxt.value     = '0;
          nxt.has_digit = 1'b0;
          nxt.bad       = 1'b0;
          if (is_final) begin
            nxt.phase = PH_TEXT;
            if (byte_in == CH_M) begin
              nxt.commit = applied;
              emit       = 1'b1;
              kind       = KIND_ATTR;
            end else begin
              nxt.work = cur.commit;
            end
          end
        end else begin
          nxt.bad = 1'b1;
        end
      end
      default: begin
        if (byte_in == CH_ESC) begin
          nxt.phase = PH_ESC;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
  end

endmodule

// ----- hw/rtl/ansi_sgr_escape_parser.sv -----
// Channel | Ports                          | Direction
// --------+--------------------------------+----------
// input   | in_valid, in_ready, in_byte    | in
// result  | out_valid, out_ready, out_kind | out
// config  | cfg_we, cfg_index, cfg_wdata   | in
//
// One byte per cycle sustained while results are taken; a beat is held in the
// input register and is parsed as it moves on into the result register.
// The parser state loop through the step logic sets the one-byte-per-cycle rate.
// rst_n is synchronous, active low; it restores the default colors 7 and 0.
// A stalled result holds a beat in the input register, which then drops in_ready.
module ansi_sgr_escape_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_wdata
);
  import asgr_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  logic       out_kind_r;
  logic [2:0] rst_fg_r;
  logic [2:0] rst_bg_r;
  pstate_t    state_r;
  pstate_t    state_nxt;
  pstate_t    state_init;
  logic       emit;
  logic       kind;
  logic       adv;

  // Move the held beat on when the result slot is free or being drained
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  asgr_step u_step (
    .cur     (state_r),
    .byte_in (in_byte_r),
    .rst_fg  (rst_fg_r),
    .rst_bg  (rst_bg_r),
    .nxt     (state_nxt),
    .emit    (emit),
    .kind    (kind)
  );

  // Reset state: plain text, no flags, default colors
  always_comb begin
    state_init           = '0;
    state_init.phase     = PH_TEXT;
    state_init.commit.fg = FG_RESET;
    state_init.commit.bg = BG_RESET;
    state_init.work      = state_init.commit;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_fg_r <= FG_RESET;
      rst_bg_r <= BG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_FG) begin
        rst_fg_r <= cfg_wdata;
      end
      if (cfg_index == CFG_IDX_BG) begin
        rst_bg_r <= cfg_wdata;
      end
    end
  end

  // Hold the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= state_init;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_kind_r <= kind;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;

endmodule
